>>> rtl/core/udp_traffic_sequence_checker_defines.svh
// Assertion macros used by the checker file of this block.
// Both sample on clk and are switched off while rst is high.
`ifndef UDP_TRAFFIC_SEQUENCE_CHECKER_DEFINES_SVH
`define UDP_TRAFFIC_SEQUENCE_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/utsc_pkg.sv
package utsc_pkg;

  localparam int NUM_CLIENTS_DEF = 8;
  // Received lengths above the buffer size are taken as the buffer size.
  localparam int BUFFER_BYTES = 4096;
  localparam logic [7:0] OVERHEAD_RESET = 8'd42;

  localparam logic [1:0] ACT_HEADER = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_END    = 2'd2;

  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        zero;
  } alu_rsp_t;

  typedef struct packed {
    logic [31:0] expected;
    logic [31:0] in_order;
    logic [31:0] seq_err;
    logic [31:0] pay_err;
  } client_rec_t;

  localparam client_rec_t REC_RESET = '{
    expected: 32'd1,
    in_order: 32'd0,
    seq_err:  32'd0,
    pay_err:  32'd0
  };

endpackage

>>> rtl/core/utsc_alu.sv
module utsc_alu import utsc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [31:0] b_eff;
  logic        carry_in;
  logic [31:0] result;

  // Subtraction is the same adder with the second operand inverted; a
  // compare for equality is a subtraction that gives zero.
  always_comb begin
    unique case (req.op)
      ALU_ADD: begin
        b_eff    = req.b;
        carry_in = 1'b0;
      end
      ALU_SUB: begin
        b_eff    = ~req.b;
        carry_in = 1'b1;
      end
    endcase
  end

  assign result     = req.a + b_eff + {31'd0, carry_in};
  assign rsp.result = result;
  assign rsp.zero   = (result == 32'd0);

endmodule

>>> rtl/core/utsc_client_mem.sv
module utsc_client_mem import utsc_pkg::*; #(
  parameter  int NUM_CLIENTS = NUM_CLIENTS_DEF,
  localparam int IDX_W       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [31:0]       addr_rd,
  output client_rec_t       rec_rd,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic              addr_we,
  input  logic [31:0]       addr_wdata,
  input  logic              rec_we,
  input  client_rec_t       rec_wdata,
  input  logic              rec_clr
);

  logic [31:0]      addr_mem [NUM_CLIENTS];
  client_rec_t      rec_mem  [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] addr_valid;
  logic [NUM_CLIENTS-1:0] rec_valid;
  logic [31:0]      addr_q;
  client_rec_t      rec_q;
  logic             addr_v_q;
  logic             rec_v_q;

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[wr_idx] <= addr_wdata;
    end
    if (rec_we) begin
      rec_mem[wr_idx] <= rec_wdata;
    end
    addr_q <= addr_mem[rd_idx];
    rec_q  <= rec_mem[rd_idx];
  end

  // A slot that was never written reads as empty, and a record that was
  // cleared reads as a fresh client, without touching the memory itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= '0;
      rec_valid  <= '0;
      addr_v_q   <= 1'b0;
      rec_v_q    <= 1'b0;
    end else begin
      if (addr_we) begin
        addr_valid[wr_idx] <= 1'b1;
      end
      if (rec_we) begin
        rec_valid[wr_idx] <= 1'b1;
      end else if (rec_clr) begin
        rec_valid[wr_idx] <= 1'b0;
      end
      addr_v_q <= addr_valid[rd_idx];
      rec_v_q  <= rec_valid[rd_idx];
    end
  end

  assign addr_rd = addr_v_q ? addr_q : 32'd0;
  assign rec_rd  = rec_v_q ? rec_q : REC_RESET;

endmodule

>>> rtl/core/udp_traffic_sequence_checker.sv
// Channel   Handshake               Carries
// input     start, busy             action and the header or payload fields
// result    done (one cycle)        verdict flags, client_index, error_sum,
//                                   in_order_count
// config    cfg_valid, cfg_ready    cfg_data: header overhead in bytes
//
// A header item scans k client slots (k from 1 to NUM_CLIENTS), one a
// cycle through the single read port of the client memory; the rest of
// its steps use the one shared adder.
// A payload byte counted as a mismatch also passes through S_PAY or S_PSUM.
// The result of an end item is shown in the cycle after it is accepted.
// Reset clears the client table at once; results cannot be stalled.
module udp_traffic_sequence_checker import utsc_pkg::*; #(
  parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] source_address,
  input  logic [31:0] sequence_number,
  input  logic [31:0] sequence_total,
  input  logic [15:0] declared_length,
  input  logic [12:0] received_length,
  input  logic [11:0] byte_offset,
  input  logic [7:0]  byte_value,
  output logic        done,
  output logic        accepted,
  output logic        sequence_mismatch,
  output logic        length_mismatch,
  output logic        unknown_source,
  output logic [2:0]  client_index,
  output logic        test_complete,
  output logic [31:0] error_sum,
  output logic [31:0] in_order_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_UNK  = 4'd4;
  localparam logic [3:0] S_SEQ  = 4'd5;
  localparam logic [3:0] S_A1   = 4'd6;
  localparam logic [3:0] S_A2   = 4'd7;
  localparam logic [3:0] S_A3   = 4'd8;
  localparam logic [3:0] S_A4   = 4'd9;
  localparam logic [3:0] S_A5   = 4'd10;
  localparam logic [3:0] S_B1   = 4'd11;
  localparam logic [3:0] S_B2   = 4'd12;
  localparam logic [3:0] S_PAY  = 4'd13;
  localparam logic [3:0] S_PSUM = 4'd14;

  logic [3:0]       state;
  logic [7:0]       header_overhead;
  logic             flag_open;
  logic             flag_acc;
  logic             flag_seqmis;
  logic             flag_lenmis;
  logic             flag_unk;
  logic             flag_cmp;
  logic [IDX_W-1:0] slot;
  logic [31:0]      unk_cnt;

  logic [IDX_W-1:0] idx;
  logic             found;
  logic [31:0]      hdr_addr;
  logic [31:0]      hdr_seq;
  logic [31:0]      hdr_total;
  logic [15:0]      hdr_decl;
  logic [12:0]      pkt_len;
  logic             zero_seen;
  logic [11:0]      zero_pos;
  logic [31:0]      pending_sum;
  logic [31:0]      pending_count;
  logic [31:0]      tmp;
  client_rec_t      w;

  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      addr_rd;
  client_rec_t      rec_rd;
  logic             addr_we;
  logic             rec_we;
  client_rec_t      rec_wdata;
  logic             rec_clr;

  logic             accept;
  logic             byte_live;
  logic [7:0]       expect_byte;
  logic             byte_bad;
  logic [12:0]      rlen_eff;
  logic             scan_empty;
  logic             scan_take;
  logic             scan_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // The payload check starts after the first zero byte, which ends the text
  // header at the front of the buffer.
  assign byte_live   = flag_open && flag_acc && ({1'b0, byte_offset} < pkt_len);
  assign expect_byte = byte_offset[0] ? byte_offset[8:1] : ~byte_offset[8:1];
  assign byte_bad    = byte_live && zero_seen && (byte_offset > zero_pos) &&
                       (byte_value != expect_byte);
  assign rlen_eff    = (32'(received_length) > 32'(BUFFER_BYTES)) ?
                       13'(BUFFER_BYTES) : received_length;

  assign scan_empty = (addr_rd == 32'd0);
  assign scan_take  = alu_rsp.zero || scan_empty;
  assign scan_last  = (idx == IDX_W'(NUM_CLIENTS - 1));
  assign wr_idx     = (state == S_SCAN) ? idx : slot;

  utsc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  utsc_client_mem #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_idx     (rd_idx),
    .addr_rd    (addr_rd),
    .rec_rd     (rec_rd),
    .wr_idx     (wr_idx),
    .addr_we    (addr_we),
    .addr_wdata (hdr_addr),
    .rec_we     (rec_we),
    .rec_wdata  (rec_wdata),
    .rec_clr    (rec_clr)
  );

  always_comb begin
    alu_req   = '{op: ALU_ADD, a: 32'd0, b: 32'd0};
    rd_idx    = slot;
    addr_we   = 1'b0;
    rec_we    = 1'b0;
    rec_clr   = 1'b0;
    rec_wdata = w;
    unique case (state)
      S_IDLE: begin
        if (accept && action == ACT_HEADER) begin
          rd_idx = '0;
        end
      end
      S_SCAN: begin
        alu_req = '{op: ALU_SUB, a: addr_rd, b: hdr_addr};
        if (scan_take) begin
          rd_idx  = idx;
          addr_we = !alu_rsp.zero;
        end else if (scan_last) begin
          rd_idx = idx;
        end else begin
          rd_idx = idx + 1'b1;
        end
      end
      S_LEN: begin
        alu_req = '{op: ALU_ADD, a: 32'(pkt_len), b: 32'(header_overhead)};
      end
      S_CHK: begin
        alu_req = '{op: ALU_SUB, a: tmp, b: 32'(hdr_decl)};
      end
      S_UNK: begin
        alu_req = '{op: ALU_ADD, a: unk_cnt, b: 32'd1};
      end
      S_SEQ: begin
        alu_req = '{op: ALU_SUB, a: hdr_seq, b: w.expected};
      end
      S_A1: begin
        alu_req = '{op: ALU_ADD, a: w.expected, b: 32'd1};
      end
      S_A2: begin
        alu_req = '{op: ALU_ADD, a: w.in_order, b: 32'd1};
      end
      S_A3: begin
        alu_req = '{op: ALU_SUB, a: hdr_seq, b: hdr_total};
        rec_we  = !alu_rsp.zero;
      end
      S_A4: begin
        alu_req = '{op: ALU_ADD, a: w.seq_err, b: unk_cnt};
      end
      S_A5: begin
        alu_req = '{op: ALU_ADD, a: tmp, b: w.pay_err};
        rec_clr = 1'b1;
      end
      S_B1: begin
        alu_req = '{op: ALU_ADD, a: hdr_seq, b: 32'd1};
      end
      S_B2: begin
        alu_req           = '{op: ALU_ADD, a: w.seq_err, b: 32'd1};
        rec_we            = 1'b1;
        rec_wdata.seq_err = alu_rsp.result;
      end
      S_PAY: begin
        alu_req           = '{op: ALU_ADD, a: rec_rd.pay_err, b: 32'd1};
        rec_we            = 1'b1;
        rec_wdata         = rec_rd;
        rec_wdata.pay_err = alu_rsp.result;
      end
      S_PSUM: begin
        alu_req = '{op: ALU_ADD, a: pending_sum, b: 32'd1};
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      header_overhead <= OVERHEAD_RESET;
      done            <= 1'b0;
      flag_open       <= 1'b0;
      flag_acc        <= 1'b0;
      flag_seqmis     <= 1'b0;
      flag_lenmis     <= 1'b0;
      flag_unk        <= 1'b0;
      flag_cmp        <= 1'b0;
      slot            <= '0;
      unk_cnt         <= 32'd0;
    end else begin
      done <= (state == S_IDLE) && accept && (action == ACT_END) && flag_open;
      if (cfg_valid && cfg_ready) begin
        header_overhead <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (action)
              ACT_HEADER: begin
                flag_open   <= (received_length != 13'd0);
                flag_acc    <= 1'b0;
                flag_seqmis <= 1'b0;
                flag_lenmis <= 1'b0;
                flag_unk    <= 1'b0;
                flag_cmp    <= 1'b0;
                if (received_length != 13'd0) begin
                  state <= S_SCAN;
                end
              end
              ACT_BYTE: begin
                if (byte_bad) begin
                  state <= flag_cmp ? S_PSUM : S_PAY;
                end
              end
              ACT_END: begin
                if (flag_open) begin
                  flag_open   <= 1'b0;
                  flag_acc    <= 1'b0;
                  flag_seqmis <= 1'b0;
                  flag_lenmis <= 1'b0;
                  flag_unk    <= 1'b0;
                  flag_cmp    <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_take) begin
            slot  <= idx;
            state <= S_LEN;
          end else if (scan_last) begin
            slot  <= '0;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (found && alu_rsp.zero) begin
            state <= S_SEQ;
          end else begin
            flag_lenmis <= !alu_rsp.zero;
            flag_unk    <= !found;
            state       <= found ? S_IDLE : S_UNK;
          end
        end
        S_UNK: begin
          unk_cnt <= alu_rsp.result;
          state   <= S_IDLE;
        end
        S_SEQ: begin
          state <= alu_rsp.zero ? S_A1 : S_B1;
        end
        S_A1: begin
          state <= S_A2;
        end
        S_A2: begin
          flag_acc <= 1'b1;
          state    <= S_A3;
        end
        S_A3: begin
          flag_cmp <= alu_rsp.zero;
          state    <= alu_rsp.zero ? S_A4 : S_IDLE;
        end
        S_A4: begin
          state <= S_A5;
        end
        S_B1: begin
          state <= S_B2;
        end
        S_B2: begin
          flag_seqmis <= 1'b1;
          state       <= S_IDLE;
        end
        S_A5, S_PAY, S_PSUM: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (action)
            ACT_HEADER: begin
              hdr_addr      <= source_address;
              hdr_seq       <= sequence_number;
              hdr_total     <= sequence_total;
              hdr_decl      <= declared_length;
              pkt_len       <= rlen_eff;
              zero_seen     <= 1'b0;
              zero_pos      <= 12'd0;
              pending_sum   <= 32'd0;
              pending_count <= 32'd0;
              idx           <= '0;
            end
            ACT_BYTE: begin
              if (byte_live && !zero_seen && byte_value == 8'd0) begin
                zero_seen <= 1'b1;
                zero_pos  <= byte_offset;
              end
            end
            ACT_END: begin
              accepted          <= flag_acc;
              sequence_mismatch <= flag_seqmis;
              length_mismatch   <= flag_lenmis;
              unknown_source    <= flag_unk;
              client_index      <= flag_unk ? 3'd0 : 3'(slot);
              test_complete     <= flag_cmp;
              error_sum         <= flag_cmp ? pending_sum : 32'd0;
              in_order_count    <= pending_count;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        found <= scan_take;
        if (!scan_take && !scan_last) begin
          idx <= idx + 1'b1;
        end
      end
      S_LEN: begin
        tmp <= alu_rsp.result;
        // Sequence one restarts the client before the in-order test.
        w   <= (hdr_seq == 32'd1) ? REC_RESET : rec_rd;
      end
      S_A1: begin
        w.expected <= alu_rsp.result;
      end
      S_A2: begin
        w.in_order    <= alu_rsp.result;
        pending_count <= alu_rsp.result;
      end
      S_A4: begin
        tmp <= alu_rsp.result;
      end
      S_A5: begin
        pending_sum <= alu_rsp.result;
      end
      S_B1: begin
        w.expected <= alu_rsp.result;
      end
      S_B2: begin
        w.seq_err     <= alu_rsp.result;
        pending_count <= w.in_order;
      end
      S_PSUM: begin
        pending_sum <= alu_rsp.result;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/utsc_checker.sv
`include "udp_traffic_sequence_checker_defines.svh"

module utsc_checker import utsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic        done,
  input logic        accepted,
  input logic        sequence_mismatch,
  input logic        unknown_source,
  input logic [2:0]  client_index,
  input logic        test_complete,
  input logic [31:0] error_sum
);

  `UTSC_ASSERT_NOW(a_unknown_no_slot, done && unknown_source, client_index == 3'd0 && !accepted, "unknown source reported with a slot or as accepted")
  `UTSC_ASSERT_NOW(a_verdict_exclusive, done, !(accepted && sequence_mismatch), "packet both in order and out of order")
  `UTSC_ASSERT_NOW(a_sum_only_on_complete, done && !test_complete, error_sum == 32'd0, "error sum on a packet that did not complete the test")
  `UTSC_ASSERT_NEXT(a_byte_gives_no_result, start && !busy && action == ACT_BYTE, !done, "payload byte item produced a result")
  `UTSC_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held for two cycles")

endmodule

bind udp_traffic_sequence_checker utsc_checker u_utsc_checker (.*);
